FILE: rtl/ptach_pkg.sv
// ============================================================================
// ptach_pkg - shared types and constants for the pulse tachometer
// Field widths, divider sizing, the command beat passed from the tick
// front end to the rpm back end, and the register map.
// ============================================================================
package ptach_pkg;

    // Time base and result format
    localparam int TIME_WIDTH    = 32;
    localparam int RPM_FRAC_BITS = 4;
    localparam int RPM_W         = 30;
    localparam int DEB_W         = 20;
    localparam int PER_W         = 26;
    localparam int CFG_W         = 32;
    localparam int ADDR_W        = 4;

    // Numerator of the rpm divide: microseconds per minute, scaled
    localparam longint unsigned US_PER_MINUTE = 64'd60000000;
    localparam longint unsigned RPM_NUM_VAL   = US_PER_MINUTE << RPM_FRAC_BITS;
    localparam int NUM_W = $clog2(RPM_NUM_VAL + 64'd1);
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [NUM_W-1:0] RPM_NUM = NUM_W'(RPM_NUM_VAL);
    localparam logic [RPM_W-1:0] RPM_MAX = '1;

    // Compare widths
    localparam int CMP_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
    localparam int LIM_W = 32;
    localparam int QX_W  = (NUM_W > RPM_W) ? NUM_W : RPM_W;

    // Command queue
    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // Register reset values
    localparam logic [DEB_W-1:0] DEB_RST     = DEB_W'(10000);
    localparam logic [PER_W-1:0] MINPER_RST  = PER_W'(1000);
    localparam logic [PER_W-1:0] TIMEOUT_RST = PER_W'(2000000);

    // Register indexes (word address)
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_MIN_PER  = 2'd1;
    localparam logic [1:0] REG_TIMEOUT  = 2'd2;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_ZERO,
        CMD_DIV
    } cmd_kind_t;

    typedef enum logic {
        BK_IDLE,
        BK_DIV
    } back_state_t;

    // One tick's worth of work for the back end
    typedef struct packed {
        cmd_kind_t               kind;
        logic [TIME_WIDTH-1:0]   period;
        logic                    new_reading;
        logic                    stopped;
    } cmd_t;

    // Clamp a quotient to the result width
    function automatic logic [RPM_W-1:0] sat_rpm(input logic [NUM_W-1:0] q);
        logic [QX_W-1:0] qx;
        qx = QX_W'(q);
        if (qx > QX_W'(RPM_MAX))
            return RPM_MAX;
        return RPM_W'(qx);
    endfunction

endpackage

FILE: rtl/ptach_front.sv
// ============================================================================
// ptach_front - tick front end
// Takes one tick beat per accept, runs edge detect, debounce wait, period
// counter and timeout check, and pushes one command per tick to the queue.
// ============================================================================
module ptach_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        pin_level,
    input  logic [ptach_pkg::DEB_W-1:0] debounce_ticks,
    input  logic [ptach_pkg::PER_W-1:0] min_period,
    input  logic [ptach_pkg::PER_W-1:0] timeout_ticks,
    input  logic                        q_full,
    output logic                        push,
    output ptach_pkg::cmd_t             cmd
);
    import ptach_pkg::*;

    logic                  prev_reg, prev_next;
    logic                  settling_reg, settling_next;
    logic [DEB_W-1:0]      settle_reg, settle_next;
    logic [TIME_WIDTH-1:0] since_reg, since_next;
    logic                  stopped_reg, stopped_next;

    logic                  check;
    logic                  accept;
    logic                  timeout;
    logic                  long_period;
    logic [TIME_WIDTH-1:0] since_inc;
    logic [LIM_W-1:0]      limit60;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // 60 * timeout as shift and subtract
    assign limit60 = (LIM_W'(timeout_ticks) << 6) - (LIM_W'(timeout_ticks) << 2);

    // Tick state update
    always_comb
    begin
        since_inc     = (since_reg == '1) ? since_reg : since_reg + 1'b1;
        check         = 1'b0;
        settling_next = settling_reg;
        settle_next   = settle_reg;

        if (settling_reg)
        begin
            if (settle_reg >= debounce_ticks)
                check = 1'b1;
            else
                settle_next = settle_reg + 1'b1;
        end
        else if (pin_level && !prev_reg)
        begin
            settling_next = 1'b1;
            if (debounce_ticks == '0)
            begin
                check       = 1'b1;
                settle_next = '0;
            end
            else
                settle_next = DEB_W'(1);
        end

        if (check)
        begin
            settling_next = 1'b0;
            settle_next   = '0;
        end

        accept      = check && pin_level
                      && (CMP_W'(since_inc) >= CMP_W'(min_period));
        long_period = CMP_W'(since_inc) >= CMP_W'(limit60);
        since_next  = accept ? '0 : since_inc;
        timeout     = CMP_W'(since_next) >= CMP_W'(timeout_ticks);

        stopped_next = stopped_reg;
        if (accept)
            stopped_next = 1'b0;
        if (timeout)
            stopped_next = 1'b1;

        prev_next = pin_level;

        // Command for the back end
        cmd.period      = since_inc;
        cmd.new_reading = accept;
        cmd.stopped     = stopped_next;
        if (timeout || (accept && long_period))
            cmd.kind = CMD_ZERO;
        else if (accept)
            cmd.kind = CMD_DIV;
        else
            cmd.kind = CMD_HOLD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg     <= 1'b0;
            settling_reg <= 1'b0;
            settle_reg   <= '0;
            since_reg    <= '0;
            stopped_reg  <= 1'b0;
        end
        else if (push)
        begin
            prev_reg     <= prev_next;
            settling_reg <= settling_next;
            settle_reg   <= settle_next;
            since_reg    <= since_next;
            stopped_reg  <= stopped_next;
        end
    end

    // An accepted pulse restarts the period count
    a_accept_clears_period: assert property (@(posedge clk) disable iff (!rst_n)
        push && cmd.new_reading |=> since_reg == '0)
        else $error("period counter not cleared after accepted pulse");

    // Outside a debounce wait the wait counter rests at zero
    a_idle_settle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !settling_reg |-> settle_reg == '0)
        else $error("debounce counter nonzero while not settling");

endmodule

FILE: rtl/ptach_queue.sv
// ============================================================================
// ptach_queue - command queue
// Short FIFO of command beats between the tick front end and the divider
// back end, so each side stalls on its own.
// ============================================================================
module ptach_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ptach_pkg::cmd_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output ptach_pkg::cmd_t q_data
);
    import ptach_pkg::*;

    cmd_t              entry_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_pop;

    assign full    = count_reg == QCNT_W'(Q_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_data  = entry_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if ((push && !full) && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (!(push && !full) && do_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(Q_DEPTH))
        else $error("queue fill count above depth");

endmodule

FILE: rtl/ptach_back.sv
// ============================================================================
// ptach_back - rpm back end
// Pops commands, runs a radix-2 restoring divide for accepted pulses,
// keeps the held rpm and drives the registered result beat.
// ============================================================================
module ptach_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  ptach_pkg::cmd_t             q_data,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ptach_pkg::RPM_W-1:0] rpm_q4,
    output logic                        new_reading,
    output logic                        stopped
);
    import ptach_pkg::*;

    back_state_t           state_reg, state_next;
    logic [RPM_W-1:0]      hold_reg, hold_next;
    logic                  out_valid_reg, out_valid_next;
    logic [RPM_W-1:0]      out_rpm_reg, out_rpm_next;
    logic                  out_new_reg, out_new_next;
    logic                  out_stop_reg, out_stop_next;
    logic [NUM_W-1:0]      quo_reg, quo_next;
    logic [TIME_WIDTH-1:0] rem_reg, rem_next;
    logic [TIME_WIDTH-1:0] div_reg, div_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  pend_new_reg, pend_new_next;
    logic                  pend_stop_reg, pend_stop_next;

    logic                  out_free;
    logic [TIME_WIDTH:0]   trial;
    logic [TIME_WIDTH:0]   diff;

    assign out_free    = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign rpm_q4      = out_rpm_reg;
    assign new_reading = out_new_reg;
    assign stopped     = out_stop_reg;

    // One divider step: shift in next numerator bit, trial subtract
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (q_valid && out_free && q_data.kind == CMD_DIV)
                    state_next = BK_DIV;
            BK_DIV:
                if (cnt_reg == '0 && out_free)
                    state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        pop            = 1'b0;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_rpm_next   = out_rpm_reg;
        out_new_next   = out_new_reg;
        out_stop_next  = out_stop_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        cnt_next       = cnt_reg;
        pend_new_next  = pend_new_reg;
        pend_stop_next = pend_stop_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    pop = 1'b1;
                    if (q_data.kind == CMD_DIV)
                    begin
                        quo_next       = RPM_NUM;
                        rem_next       = '0;
                        div_next       = q_data.period;
                        cnt_next       = CNT_W'(NUM_W);
                        pend_new_next  = q_data.new_reading;
                        pend_stop_next = q_data.stopped;
                    end
                    else
                    begin
                        if (q_data.kind == CMD_ZERO)
                            hold_next = '0;
                        out_valid_next = 1'b1;
                        out_rpm_next   = (q_data.kind == CMD_ZERO) ? '0 : hold_reg;
                        out_new_next   = q_data.new_reading;
                        out_stop_next  = q_data.stopped;
                    end
                end
            end
            BK_DIV:
            begin
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (!diff[TIME_WIDTH])
                    begin
                        rem_next = diff[TIME_WIDTH-1:0];
                        quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = trial[TIME_WIDTH-1:0];
                        quo_next = {quo_reg[NUM_W-2:0], 1'b0};
                    end
                end
                else if (out_free)
                begin
                    hold_next      = sat_rpm(quo_reg);
                    out_valid_next = 1'b1;
                    out_rpm_next   = sat_rpm(quo_reg);
                    out_new_next   = pend_new_reg;
                    out_stop_next  = pend_stop_reg;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            hold_reg      <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        out_rpm_reg   <= out_rpm_next;
        out_new_reg   <= out_new_next;
        out_stop_reg  <= out_stop_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        div_reg       <= div_next;
        pend_new_reg  <= pend_new_next;
        pend_stop_reg <= pend_stop_next;
    end

    // No command is taken while a divide is running
    a_no_pop_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_DIV |-> !pop)
        else $error("queue popped during divide");

    // Step counter never exceeds the quotient width
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(NUM_W))
        else $error("divide step count out of range");

endmodule

FILE: rtl/pulse_tachometer_rpm.sv
// ============================================================================
// pulse_tachometer_rpm - period-measuring tachometer, rpm in 1/16 units
// One tick beat in, one result beat out. Front end debounces and times
// pulses; back end divides scaled microseconds-per-minute by the period.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   in      | input     | in_valid/in_stall  | pin_level
//   out     | output    | out_valid/out_stall| rpm_q4, new_reading, stopped
//   cfg     | input     | APB psel/penable   | debounce_ticks, min_period,
//           |           |                    | timeout_ticks at 0x0/0x4/0x8
//
// A tick that needs no divide is answered from the held rpm, or as zero. A
// tick with an accepted pulse of normal length runs the radix-2 restoring
// divider, one quotient bit a cycle, before its result beat goes out.
// The four-entry command queue lets the front end keep taking ticks while
// the divider runs; in_stall rises only when that queue is full.
// Reset clears all timing state and loads register defaults; no clearing
// pass is needed. A stalled output holds its beat and takes no new command.
// ============================================================================
module pulse_tachometer_rpm (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         pin_level,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ptach_pkg::RPM_W-1:0]  rpm_q4,
    output logic                         new_reading,
    output logic                         stopped,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ptach_pkg::ADDR_W-1:0] paddr,
    input  logic [ptach_pkg::CFG_W-1:0]  pwdata,
    output logic [ptach_pkg::CFG_W-1:0]  prdata,
    output logic                         pready
);
    import ptach_pkg::*;

    logic [DEB_W-1:0] deb_reg;
    logic [PER_W-1:0] minper_reg;
    logic [PER_W-1:0] timeout_reg;
    logic             wr_en;
    logic [1:0]       reg_idx;

    logic             q_full;
    logic             push;
    cmd_t             push_cmd;
    logic             pop;
    logic             q_valid;
    cmd_t             q_data;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_reg     <= DEB_RST;
            minper_reg  <= MINPER_RST;
            timeout_reg <= TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_DEBOUNCE: deb_reg     <= pwdata[DEB_W-1:0];
                REG_MIN_PER:  minper_reg  <= pwdata[PER_W-1:0];
                REG_TIMEOUT:  timeout_reg <= pwdata[PER_W-1:0];
                default:      deb_reg     <= deb_reg;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        unique case (reg_idx)
            REG_DEBOUNCE: prdata = CFG_W'(deb_reg);
            REG_MIN_PER:  prdata = CFG_W'(minper_reg);
            REG_TIMEOUT:  prdata = CFG_W'(timeout_reg);
            default:      prdata = '0;
        endcase
    end

    ptach_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pin_level      (pin_level),
        .debounce_ticks (deb_reg),
        .min_period     (minper_reg),
        .timeout_ticks  (timeout_reg),
        .q_full         (q_full),
        .push           (push),
        .cmd            (push_cmd)
    );

    ptach_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    ptach_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .rpm_q4      (rpm_q4),
        .new_reading (new_reading),
        .stopped     (stopped)
    );

endmodule
